>>> src/pba_pkg.sv
// ----------------------------------------------------------------------------
// pba_pkg
// Shared types, sizes and codes for the page bitmap allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package pba_pkg;

   localparam int MAX_PAGES = 65536;
   localparam int WORD_BITS = 64;
   localparam int NUM_WORDS = MAX_PAGES / WORD_BITS;
   localparam int BIT_W     = $clog2(WORD_BITS);
   localparam int WADDR_W   = $clog2(NUM_WORDS);
   localparam int LIMIT_W   = 11;
   localparam int PAGE_W    = 16;
   localparam int COUNT_W   = 17;
   localparam int BYTES_W   = WORD_BITS / 8;
   localparam int BSEL_W    = $clog2(BYTES_W);

   localparam logic [COUNT_W-1:0] NO_PAGE   = '1;
   localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

   localparam logic [1:0] KIND_ALLOC = 2'd0;
   localparam logic [1:0] KIND_NEXT  = 2'd1;
   localparam logic [1:0] KIND_FREE  = 2'd2;
   localparam logic [1:0] KIND_QUERY = 2'd3;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_SAME  = 2'd1;
   localparam logic [1:0] ST_RANGE = 2'd2;
   localparam logic [1:0] ST_NONE  = 2'd3;

   typedef struct packed {
      logic [1:0]        kind;
      logic [PAGE_W-1:0] page_index;
   } req_type;

   typedef struct packed {
      logic [PAGE_W-1:0]  result_page;
      logic [1:0]         status;
      logic               page_free;
      logic [COUNT_W-1:0] free_count;
   } rsp_type;

   typedef struct packed {
      logic                 rd_en;
      logic [WADDR_W-1:0]   rd_addr;
      logic                 wr_en;
      logic [WADDR_W-1:0]   wr_addr;
      logic [WORD_BITS-1:0] wr_data;
   } mem_req_type;

   typedef struct packed {
      logic             found;
      logic [BIT_W-1:0] bit_idx;
   } scan_res_type;

endpackage

`default_nettype wire

>>> src/page_bitmap_allocator.sv
// ----------------------------------------------------------------------------
// page_bitmap_allocator
// Bitmap page frame allocator with free count and lowest-free hint.
//
//   channel   signals                         direction
//   req       req_valid req_stall req_data    in  (kind, page_index)
//   rsp       rsp_valid rsp_stall rsp_data    out (page, status, free, count)
//   csr       csr_wr_en csr_wr_data           in  (words_in_use)
//
// a request runs through accept, bitmap word read, update and result load
// allocating the hinted page adds a scan for the next free page, a bitmap word
// read and evaluation per word, and a final limit check when it runs to the limit
// a request refused before the bitmap read goes from accept straight to result load
// after reset all 1024 bitmap words are set to all used, no request taken
// the next request is taken while a result waits on rsp_stall
// ----------------------------------------------------------------------------
`default_nettype none

module page_bitmap_allocator
   import pba_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire req_type            req_data,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output rsp_type                 rsp_data,
   input  wire logic               csr_wr_en,
   input  wire logic [LIMIT_W-1:0] csr_wr_data
);

   localparam logic [2:0] S_CLEAR     = 3'd0;
   localparam logic [2:0] S_IDLE      = 3'd1;
   localparam logic [2:0] S_READ      = 3'd2;
   localparam logic [2:0] S_EXEC      = 3'd3;
   localparam logic [2:0] S_SCAN_RD   = 3'd4;
   localparam logic [2:0] S_SCAN_EVAL = 3'd5;
   localparam logic [2:0] S_DONE      = 3'd6;

   logic [2:0]           state_ff, state_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_type              rsp_data_ff, rsp_data_in;
   logic [LIMIT_W-1:0]   words_in_use_ff, words_in_use_in;
   logic [COUNT_W-1:0]   free_count_ff, free_count_in;
   logic [COUNT_W-1:0]   hint_ff, hint_in;
   logic [1:0]           kind_ff, kind_in;
   logic [PAGE_W-1:0]    target_ff, target_in;
   logic [PAGE_W-1:0]    res_page_ff, res_page_in;
   logic [1:0]           status_ff, status_in;
   logic                 pfree_ff, pfree_in;
   logic [LIMIT_W-1:0]   scan_word_ff, scan_word_in;
   logic [BIT_W-1:0]     scan_bit_ff, scan_bit_in;

   mem_req_type          mem_req;
   logic [WORD_BITS-1:0] rd_word;
   logic                 store_busy;
   scan_res_type         scan_res;

   logic [LIMIT_W-1:0]   limit;
   logic [LIMIT_W-1:0]   req_word;
   logic [LIMIT_W-1:0]   hint_word;
   logic [COUNT_W-1:0]   next_page;
   logic                 bit_used;
   logic [WORD_BITS-1:0] bit_mask;

   pba_bitmap_store u_store (
      .clock   (clock),
      .reset   (reset),
      .mem_req (mem_req),
      .rd_word (rd_word),
      .busy    (store_busy)
   );

   pba_scan_unit u_scan (
      .word      (rd_word),
      .start_bit (scan_bit_ff),
      .result    (scan_res)
   );

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      limit     = (words_in_use_ff > LIMIT_W'(NUM_WORDS)) ? LIMIT_W'(NUM_WORDS)
                                                          : words_in_use_ff;
      req_word  = LIMIT_W'(req_data.page_index[PAGE_W-1:BIT_W]);
      hint_word = hint_ff[COUNT_W-1:BIT_W];
      next_page = COUNT_W'(target_ff) + 1'b1;
      bit_used  = rd_word[target_ff[BIT_W-1:0]];
      bit_mask  = {{(WORD_BITS-1){1'b0}}, 1'b1} << target_ff[BIT_W-1:0];

      state_in        = state_ff;
      rsp_valid_in    = rsp_valid_ff;
      rsp_data_in     = rsp_data_ff;
      words_in_use_in = words_in_use_ff;
      free_count_in   = free_count_ff;
      hint_in         = hint_ff;
      kind_in         = kind_ff;
      target_in       = target_ff;
      res_page_in     = res_page_ff;
      status_in       = status_ff;
      pfree_in        = pfree_ff;
      scan_word_in    = scan_word_ff;
      scan_bit_in     = scan_bit_ff;

      mem_req.rd_en   = 1'b0;
      mem_req.rd_addr = target_ff[PAGE_W-1:BIT_W];
      mem_req.wr_en   = 1'b0;
      mem_req.wr_addr = target_ff[PAGE_W-1:BIT_W];
      mem_req.wr_data = rd_word | bit_mask;

      if (csr_wr_en) begin
         words_in_use_in = csr_wr_data;
      end
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         S_CLEAR: begin
            if (!store_busy) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_valid) begin
               kind_in   = req_data.kind;
               pfree_in  = 1'b0;
               status_in = ST_DONE;
               if (req_data.kind == KIND_NEXT) begin
                  target_in   = hint_ff[PAGE_W-1:0];
                  res_page_in = hint_ff[PAGE_W-1:0];
                  if (hint_ff == NO_PAGE || hint_word >= limit) begin
                     status_in   = ST_NONE;
                     res_page_in = '0;
                     state_in    = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end else begin
                  target_in   = req_data.page_index;
                  res_page_in = req_data.page_index;
                  if (req_word >= limit) begin
                     status_in = ST_RANGE;
                     state_in  = S_DONE;
                  end else begin
                     state_in = S_READ;
                  end
               end
            end
         end
         S_READ: begin
            mem_req.rd_en = 1'b1;
            state_in      = S_EXEC;
         end
         S_EXEC: begin
            state_in = S_DONE;
            case (kind_ff)
               KIND_ALLOC, KIND_NEXT: begin
                  if (bit_used) begin
                     if (kind_ff == KIND_NEXT) begin
                        status_in   = ST_NONE;
                        res_page_in = '0;
                     end else begin
                        status_in = ST_SAME;
                     end
                  end else begin
                     mem_req.wr_en = 1'b1;
                     if (free_count_ff != '0) begin
                        free_count_in = free_count_ff - 1'b1;
                     end
                     if (COUNT_W'(target_ff) == hint_ff) begin
                        scan_word_in = next_page[COUNT_W-1:BIT_W];
                        scan_bit_in  = next_page[BIT_W-1:0];
                        state_in     = S_SCAN_RD;
                     end
                  end
               end
               KIND_FREE: begin
                  if (!bit_used) begin
                     status_in = ST_SAME;
                  end else begin
                     mem_req.wr_en   = 1'b1;
                     mem_req.wr_data = rd_word & ~bit_mask;
                     if (free_count_ff != COUNT_MAX) begin
                        free_count_in = free_count_ff + 1'b1;
                     end
                     if (COUNT_W'(target_ff) < hint_ff) begin
                        hint_in = COUNT_W'(target_ff);
                     end
                  end
               end
               default: begin
                  pfree_in = ~bit_used;
               end
            endcase
         end
         S_SCAN_RD: begin
            mem_req.rd_addr = scan_word_ff[WADDR_W-1:0];
            if (scan_word_ff >= limit) begin
               hint_in  = NO_PAGE;
               state_in = S_DONE;
            end else begin
               mem_req.rd_en = 1'b1;
               state_in      = S_SCAN_EVAL;
            end
         end
         S_SCAN_EVAL: begin
            if (scan_res.found) begin
               hint_in  = COUNT_W'({scan_word_ff[WADDR_W-1:0], scan_res.bit_idx});
               state_in = S_DONE;
            end else begin
               scan_word_in = scan_word_ff + 1'b1;
               scan_bit_in  = '0;
               state_in     = S_SCAN_RD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in.result_page = res_page_ff;
               rsp_data_in.status      = status_ff;
               rsp_data_in.page_free   = pfree_ff;
               rsp_data_in.free_count  = free_count_ff;
               rsp_valid_in            = 1'b1;
               state_in                = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_CLEAR;
         rsp_valid_ff    <= 1'b0;
         words_in_use_ff <= '0;
         free_count_ff   <= '0;
         hint_ff         <= NO_PAGE;
      end else begin
         state_ff        <= state_in;
         rsp_valid_ff    <= rsp_valid_in;
         words_in_use_ff <= words_in_use_in;
         free_count_ff   <= free_count_in;
         hint_ff         <= hint_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      kind_ff      <= kind_in;
      target_ff    <= target_in;
      res_page_ff  <= res_page_in;
      status_ff    <= status_in;
      pfree_ff     <= pfree_in;
      scan_word_ff <= scan_word_in;
      scan_bit_ff  <= scan_bit_in;
   end

   // no request taken during the set-all pass
   a_clear_blocks: assert property (@(posedge clock) disable iff (reset)
      store_busy |-> req_stall)
      else $error("request taken during bitmap clear");

   // apart from the set-all pass, bitmap only changes in the update step
   a_write_exec: assert property (@(posedge clock) disable iff (reset)
      mem_req.wr_en |-> (state_ff == S_EXEC))
      else $error("bitmap write outside update step");

   // hint is a real page or the none marker
   a_hint_form: assert property (@(posedge clock) disable iff (reset)
      hint_ff[COUNT_W-1] |-> (hint_ff == NO_PAGE))
      else $error("malformed lowest-free hint");

   // an accepted request never finishes in the same cycle
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> (state_ff != S_IDLE))
      else $error("sequencer idle right after accept");

endmodule

`default_nettype wire

>>> src/pba_scan_unit.sv
// ----------------------------------------------------------------------------
// pba_scan_unit
// Finds the lowest free page bit of a bitmap word at or above a start bit.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_scan_unit
   import pba_pkg::*;
(
   input  wire logic [WORD_BITS-1:0] word,
   input  wire logic [BIT_W-1:0]     start_bit,
   output scan_res_type              result
);

   logic [WORD_BITS-1:0] free_bits;
   logic [BYTES_W-1:0]   byte_any;
   logic [BSEL_W-1:0]    byte_sel;
   logic [7:0]           byte_bits;
   logic [2:0]           bit_sel;

   always_comb begin
      for (int i = 0; i < WORD_BITS; i++) begin
         free_bits[i] = ~word[i] && (BIT_W'(i) >= start_bit);
      end
      for (int j = 0; j < BYTES_W; j++) begin
         byte_any[j] = |free_bits[j*8 +: 8];
      end
      byte_sel = '0;
      for (int j = BYTES_W - 1; j >= 0; j--) begin
         if (byte_any[j]) begin
            byte_sel = BSEL_W'(j);
         end
      end
      byte_bits = free_bits[byte_sel*8 +: 8];
      bit_sel = '0;
      for (int k = 7; k >= 0; k--) begin
         if (byte_bits[k]) begin
            bit_sel = 3'(k);
         end
      end
      result.found   = |byte_any;
      result.bit_idx = {byte_sel, bit_sel};
   end

endmodule

`default_nettype wire

>>> src/pba_bitmap_store.sv
// ----------------------------------------------------------------------------
// pba_bitmap_store
// Bitmap word memory with registered read and a set-all pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module pba_bitmap_store
   import pba_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire mem_req_type          mem_req,
   output logic [WORD_BITS-1:0]      rd_word,
   output logic                      busy
);

   logic [WORD_BITS-1:0] mem [NUM_WORDS];
   logic [WORD_BITS-1:0] rd_word_ff;
   logic [WADDR_W:0]     clr_cnt_ff;
   logic [WADDR_W:0]     clr_cnt_in;
   logic                 wr_en;
   logic [WADDR_W-1:0]   wr_addr;
   logic [WORD_BITS-1:0] wr_data;

   assign busy = ~clr_cnt_ff[WADDR_W];

   always_comb begin
      clr_cnt_in = clr_cnt_ff;
      if (busy) begin
         clr_cnt_in = clr_cnt_ff + 1'b1;
      end
      wr_en   = busy | mem_req.wr_en;
      wr_addr = busy ? clr_cnt_ff[WADDR_W-1:0] : mem_req.wr_addr;
      wr_data = busy ? '1 : mem_req.wr_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else begin
         clr_cnt_ff <= clr_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_req.rd_en) begin
         rd_word_ff <= mem[mem_req.rd_addr];
      end
   end

   assign rd_word = rd_word_ff;

endmodule

`default_nettype wire
